// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the life generation engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define LGE_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge out of reset.
`define LGE_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== rtl/lge_pkg.sv =====
// Shared constants, types and a helper function of the life generation engine.
package lge_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 2);
  localparam int OP_W      = 2;
  localparam int POS_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W     = 4;

  typedef logic [MAX_COLS-1:0] row_bits_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic load_item;
    logic clear_res;
    logic take_cell;
    logic write_cell;
    logic sweep_init;
    logic sweep_run;
    logic swap;
    logic step_res;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_grid;
    logic            sweep_done;
    logic            slot_free;
  } sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lge_in_if.sv =====
// Input item channel: valid/ready handshake with the cell operation payload.
interface lge_in_if;
  logic                      valid;
  logic                      ready;
  logic [lge_pkg::OP_W-1:0]  operation;
  logic [lge_pkg::POS_W-1:0] row;
  logic [lge_pkg::POS_W-1:0] col;
  logic                      cell_value;

  modport source(output valid, operation, row, col, cell_value, input ready);
  modport sink(input valid, operation, row, col, cell_value, output ready);
endinterface

// ===== rtl/lge_out_if.sv =====
// Result channel: valid/ready handshake with the read bit and step completion flag.
interface lge_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic step_done;

  modport source(output valid, cell_alive, step_done, input ready);
  modport sink(input valid, cell_alive, step_done, output ready);
endinterface

// ===== rtl/lge_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
interface lge_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lge_pkg::CFG_IDX_W-1:0] index;
  logic [lge_pkg::SIZE_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/lge_ctrl.sv =====
// Controller state machine that sequences cell accesses and generation sweeps.
module lge_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lge_pkg::sts_t sts,
  output lge_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_ROW    = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clear_res = 1'b1;
        case (sts.op)
          lge_pkg::OP_WRITE: state_nxt = sts.in_grid ? ST_ROW : ST_IDLE;
          lge_pkg::OP_READ:  state_nxt = sts.in_grid ? ST_ROW : ST_RESULT;
          lge_pkg::OP_STEP: begin
            cmd.sweep_init = 1'b1;
            state_nxt      = ST_SWEEP;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_ROW: begin
        // The row read issued in the decode cycle is now available.
        if (sts.op == lge_pkg::OP_WRITE) begin
          cmd.write_cell = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.take_cell = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          cmd.swap     = 1'b1;
          cmd.step_res = 1'b1;
          state_nxt    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lge_datapath.sv =====
// Datapath: two row-organised grid banks, sweep window, neighbour rule and result register.
module lge_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lge_pkg::OP_W-1:0]     in_operation,
  input  logic [lge_pkg::POS_W-1:0]    in_row,
  input  logic [lge_pkg::POS_W-1:0]    in_col,
  input  logic                         in_cell_value,
  input  logic [lge_pkg::SIZE_W-1:0]   rows_use,
  input  logic [lge_pkg::SIZE_W-1:0]   cols_use,
  input  logic                         out_ready,
  input  lge_pkg::cmd_t                cmd,
  output lge_pkg::sts_t                sts,
  output logic                         out_valid,
  output logic                         out_cell_alive,
  output logic                         out_step_done
);

  localparam int ROW_W    = lge_pkg::ROW_W;
  localparam int COL_W    = lge_pkg::COL_W;
  localparam int CNT_W    = lge_pkg::CNT_W;
  localparam int MAX_ROWS = lge_pkg::MAX_ROWS;
  localparam int MAX_COLS = lge_pkg::MAX_COLS;
  localparam int NBR_W    = lge_pkg::NBR_W;

  // Latched input item.
  logic [lge_pkg::OP_W-1:0]  item_op_r;
  logic [lge_pkg::POS_W-1:0] item_row_r;
  logic [lge_pkg::POS_W-1:0] item_col_r;
  logic                      item_val_r;

  // Grid banks, one row per entry, with a valid bit per row standing for the cleared state.
  lge_pkg::row_bits_t mem_a [MAX_ROWS];
  lge_pkg::row_bits_t mem_b [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_a_r;
  logic [MAX_ROWS-1:0] vld_b_r;
  logic                active_r;

  lge_pkg::row_bits_t rd_a_r;
  lge_pkg::row_bits_t rd_b_r;
  logic               rd_va_r;
  logic               rd_vb_r;

  // Sweep sequencing and three-row window.
  logic [CNT_W-1:0]   k_r;
  logic               rd_live_r;
  logic [CNT_W-1:0]   rd_idx_r;
  lge_pkg::row_bits_t above_r;
  lge_pkg::row_bits_t cur_r;

  logic res_alive_r;
  logic res_done_r;
  logic out_valid_r;
  logic out_alive_r;
  logic out_done_r;

  logic [ROW_W-1:0]   rd_addr;
  logic [COL_W-1:0]   col_idx;
  logic               issue;
  lge_pkg::row_bits_t src_row;
  lge_pkg::row_bits_t cell_row;
  lge_pkg::row_bits_t col_mask;
  lge_pkg::row_bits_t next_row;
  lge_pkg::row_bits_t sweep_row;
  logic [MAX_COLS+1:0] pad_a;
  logic [MAX_COLS+1:0] pad_c;
  logic [MAX_COLS+1:0] pad_b;
  logic [NBR_W-1:0]    nbr [MAX_COLS];
  logic                below_use;
  logic                cur_use;

  logic               wr_en;
  logic               wr_bank;
  logic [ROW_W-1:0]   wr_addr;
  lge_pkg::row_bits_t wr_data;

  assign col_idx = COL_W'(item_col_r);
  assign issue   = cmd.sweep_run && (k_r <= CNT_W'(MAX_ROWS));
  assign rd_addr = cmd.sweep_run ? k_r[ROW_W-1:0] : ROW_W'(item_row_r);

  always_comb begin
    if (active_r) begin
      src_row = rd_vb_r ? rd_b_r : '0;
    end else begin
      src_row = rd_va_r ? rd_a_r : '0;
    end
  end

  always_comb begin
    cell_row          = src_row;
    cell_row[col_idx] = item_val_r;
  end

  // Next generation of the row in the middle of the window.
  always_comb begin
    below_use = int'(rd_idx_r) < int'(rows_use);
    cur_use   = (int'(rd_idx_r) - 1) < int'(rows_use);
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = c < int'(cols_use);
    end
    pad_a = {1'b0, above_r & col_mask, 1'b0};
    pad_c = {1'b0, cur_r & col_mask, 1'b0};
    pad_b = {1'b0, (below_use ? src_row : '0) & col_mask, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr[c] = NBR_W'(pad_a[c]) + NBR_W'(pad_a[c+1]) + NBR_W'(pad_a[c+2])
             + NBR_W'(pad_c[c]) + NBR_W'(pad_c[c+2])
             + NBR_W'(pad_b[c]) + NBR_W'(pad_b[c+1]) + NBR_W'(pad_b[c+2]);
      if (col_mask[c]) begin
        next_row[c] = (nbr[c] == NBR_W'(3)) || ((nbr[c] == NBR_W'(2)) && cur_r[c]);
      end else begin
        next_row[c] = cur_r[c];
      end
    end
    sweep_row = cur_use ? next_row : cur_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = active_r;
    wr_addr = ROW_W'(item_row_r);
    wr_data = cell_row;
    if (cmd.write_cell) begin
      wr_en = 1'b1;
    end else if (rd_live_r && (rd_idx_r != '0)) begin
      wr_en   = 1'b1;
      wr_bank = ~active_r;
      wr_addr = ROW_W'(rd_idx_r - CNT_W'(1));
      wr_data = sweep_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_a_r  <= mem_a[rd_addr];
    rd_b_r  <= mem_b[rd_addr];
    rd_va_r <= vld_a_r[rd_addr];
    rd_vb_r <= vld_b_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      active_r    <= 1'b0;
      k_r         <= '0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en && !wr_bank) begin
        vld_a_r[wr_addr] <= 1'b1;
      end
      if (wr_en && wr_bank) begin
        vld_b_r[wr_addr] <= 1'b1;
      end
      if (cmd.swap) begin
        active_r <= ~active_r;
      end
      if (cmd.sweep_init) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + CNT_W'(1);
      end
      rd_live_r <= issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op_r  <= in_operation;
      item_row_r <= in_row;
      item_col_r <= in_col;
      item_val_r <= in_cell_value;
    end
    if (issue) begin
      rd_idx_r <= k_r;
    end
    if (cmd.sweep_init) begin
      above_r <= '0;
      cur_r   <= '0;
    end else if (rd_live_r) begin
      above_r <= cur_r;
      cur_r   <= src_row;
    end
    if (cmd.clear_res) begin
      res_alive_r <= 1'b0;
      res_done_r  <= 1'b0;
    end else if (cmd.take_cell) begin
      res_alive_r <= src_row[col_idx];
    end else if (cmd.step_res) begin
      res_done_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_alive_r <= res_alive_r;
      out_done_r  <= res_done_r;
    end
  end

  assign sts.op         = item_op_r;
  assign sts.in_grid    = ({1'b0, item_row_r} < rows_use) && ({1'b0, item_col_r} < cols_use);
  assign sts.sweep_done = rd_live_r && (rd_idx_r == CNT_W'(MAX_ROWS));
  assign sts.slot_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_alive_r;
  assign out_step_done  = out_done_r;

endmodule

// ===== rtl/life_generation_engine_unit.sv =====
// Top level of the life generation engine: configuration registers, controller and datapath.
//
// The block keeps a bounded grid of one-bit cells and takes one item at a time on in_ch.
// An item writes a cell (no result), reads a cell (one result carrying cell_alive) or
// advances the whole grid by one generation (one result with step_done set). Cells
// outside the configured size count as dead and are left untouched by a generation.
// The grid sits in two row-wide banks; a generation reads the active bank one row per
// cycle through a three-row window and writes the other bank, then the banks swap roles.
// Sequence after the input transfer: a write passes the decode and row states and then
// frees the input, a read passes the decode and row states and loads its result into the
// output register from the result state (either skips the row state when the cell lies
// outside the grid in use), and a generation is bounded by the single row read port.
// Configuration writes on cfg_ch are always taken; they must only be made while idle.
// Reset empties the grid at once through per-row valid bits, so there is no clearing pass
// and the first item may follow straight after reset; both sizes return to their maximum.
// Results wait in an output register: while the receiver stalls, writes keep being taken
// and an item that produces a result waits until the pending one has been transferred.
`include "assert_macros.svh"

module life_generation_engine_unit (
  input  logic      clk,
  input  logic      rst_n,
  lge_in_if.sink    in_ch,
  lge_out_if.source out_ch,
  lge_cfg_if.sink   cfg_ch
);

  // Grid size in use, held already clamped into its legal range.
  logic [lge_pkg::SIZE_W-1:0] rows_use_r;
  logic [lge_pkg::SIZE_W-1:0] cols_use_r;

  lge_pkg::cmd_t cmd;
  lge_pkg::sts_t sts;
  logic          in_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_use_r <= lge_pkg::SIZE_W'(lge_pkg::MAX_ROWS);
      cols_use_r <= lge_pkg::SIZE_W'(lge_pkg::MAX_COLS);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lge_pkg::CFG_GRID_ROWS: begin
          rows_use_r <= lge_pkg::clamp_size(cfg_ch.data,
                                            lge_pkg::SIZE_W'(lge_pkg::MAX_ROWS));
        end
        lge_pkg::CFG_GRID_COLS: begin
          cols_use_r <= lge_pkg::clamp_size(cfg_ch.data,
                                            lge_pkg::SIZE_W'(lge_pkg::MAX_COLS));
        end
        default: begin
          rows_use_r <= rows_use_r;
        end
      endcase
    end
  end

  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lge_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_ch.operation),
    .in_row         (in_ch.row),
    .in_col         (in_ch.col),
    .in_cell_value  (in_ch.cell_value),
    .rows_use       (rows_use_r),
    .cols_use       (cols_use_r),
    .out_ready      (out_ch.ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_cell_alive (out_ch.cell_alive),
    .out_step_done  (out_ch.step_done)
  );

  // A sweep must never overlap the acceptance of a new item.
  `LGE_ASSERT_IMPLIES(a_sweep_blocks_input, cmd.sweep_run, !in_ready, "input open during sweep")
  // The last row of a sweep must swap the banks and flag the step result together.
  `LGE_ASSERT_IMPLIES(a_sweep_end_swaps, sts.sweep_done, cmd.swap && cmd.step_res, "sweep end lost")
  // A result may only enter the output register when it is empty or the pending one is leaving.
  `LGE_ASSERT_IMPLIES(a_result_slot_free, cmd.load_out, sts.slot_free, "result overwritten")
  // Item load, cell write, sweep and result load belong to distinct controller phases.
  `LGE_ASSERT_ALWAYS(a_phases_exclusive,
    $onehot0({cmd.load_item, cmd.write_cell, cmd.sweep_run, cmd.load_out}), "phases overlap")

endmodule

// ===== sim/tb_life_generation_engine_unit.sv =====
// Self-checking testbench of the life generation engine: directed table, random phases, hold-off flood.
module tb_life_generation_engine_unit;
  import lge_pkg::*;

  // Operation code that the block must ignore without producing a result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A write gives no result and frees the input once the block is back in idle, so this
  // many quiet cycles after the last result are enough before touching the sizes.
  localparam int WRITE_SETTLE = 20;
  // The tail wait covers a full generation with margin.
  localparam int TAIL_CYCLES  = 150;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int LONG_HOLD    = 300;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT  = 5000;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_SET_ROWS,
    ROW_SET_COLS
  } row_kind_t;

  // One line of the directed table. Where fixed is set, alive and done are the
  // result typed in by hand; otherwise the grid predictor supplies it.
  typedef struct packed {
    row_kind_t          kind;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               val;
    logic [SIZE_W-1:0]  size;
    logic               fixed;
    logic               alive;
    logic               done;
  } stim_row_t;

  typedef struct packed {
    logic alive;
    logic done;
  } cell_result_t;

  // The directed part: extremes, every operation, the ignored code, writes and
  // reads outside a shrunken grid, and cells outside the grid surviving a generation.
  localparam int DIRECTED_LEN = 29;
  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{ROW_ITEM,     OP_READ,   6'd0,  6'd0,  1'b0, 7'd0,  1'b1, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd63, 6'd63, 1'b0, 7'd0,  1'b1, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd0,  6'd0,  1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd0,  6'd0,  1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd63, 6'd63, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_UNUSED, 6'd63, 6'd63, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd63, 6'd63, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd63, 6'd63, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd63, 6'd63, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd10, 6'd10, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd10, 6'd11, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd10, 6'd12, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_STEP,   6'd0,  6'd0,  1'b0, 7'd0,  1'b1, 1'b0, 1'b1},
    '{ROW_ITEM,     OP_READ,   6'd9,  6'd11, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd10, 6'd10, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_STEP,   6'd0,  6'd0,  1'b0, 7'd0,  1'b1, 1'b0, 1'b1},
    '{ROW_ITEM,     OP_READ,   6'd10, 6'd10, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd40, 6'd40, 1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_SET_ROWS, OP_WRITE,  6'd0,  6'd0,  1'b0, 7'd4,  1'b0, 1'b0, 1'b0},
    '{ROW_SET_COLS, OP_WRITE,  6'd0,  6'd0,  1'b0, 7'd5,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_WRITE,  6'd4,  6'd0,  1'b1, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd4,  6'd0,  1'b0, 7'd0,  1'b1, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd0,  6'd5,  1'b0, 7'd0,  1'b1, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_STEP,   6'd0,  6'd0,  1'b0, 7'd0,  1'b1, 1'b0, 1'b1},
    '{ROW_SET_ROWS, OP_WRITE,  6'd0,  6'd0,  1'b0, 7'd64, 1'b0, 1'b0, 1'b0},
    '{ROW_SET_COLS, OP_WRITE,  6'd0,  6'd0,  1'b0, 7'd64, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd40, 6'd40, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd4,  6'd0,  1'b0, 7'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_ITEM,     OP_READ,   6'd10, 6'd11, 1'b0, 7'd0,  1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;

  lge_in_if  in_bus ();
  lge_out_if out_bus ();
  lge_cfg_if cfg_bus ();

  life_generation_engine_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Predicted state: the live grid as the block should hold it, and the raw size
  // registers as last written. Only the active grid matters, because a generation
  // copies every cell outside the grid in use over to the new bank unchanged.
  bit                 life_grid [MAX_ROWS][MAX_COLS];
  logic [SIZE_W-1:0]  rows_reg;
  logic [SIZE_W-1:0]  cols_reg;
  cell_result_t       expected_results [$];

  int error_count;
  // When set, neither side idles: used for stretches of back-to-back transfers.
  bit no_idle;
  // Raised by the sender to ask the receiver for one long hold-off.
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A size register of zero acts as one, and anything above the maximum as the maximum.
  function automatic int extent_of(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // One generation over the grid in use, reading only the old grid. Neighbours
  // beyond the edge of the grid in use count as dead.
  function automatic void advance_generation();
    bit next_grid [MAX_ROWS][MAX_COLS];
    int rows;
    int cols;
    int live;
    int rr;
    int cc;
    rows = extent_of(rows_reg, MAX_ROWS);
    cols = extent_of(cols_reg, MAX_COLS);
    next_grid = life_grid;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < rows && cc >= 0 && cc < cols) begin
              live += life_grid[rr][cc];
            end
          end
        end
        if (live < 2 || live > 3) begin
          next_grid[r][c] = 1'b0;
        end else if (live == 3) begin
          next_grid[r][c] = 1'b1;
        end
      end
    end
    life_grid = next_grid;
  endfunction

  // Applies one accepted item to the predicted grid; returns 1 when it yields a result.
  function automatic bit predict_cell_op(input logic [OP_W-1:0] op,
                                         input logic [POS_W-1:0] row,
                                         input logic [POS_W-1:0] col,
                                         input logic val,
                                         output cell_result_t res);
    bit in_grid;
    in_grid = (int'(row) < extent_of(rows_reg, MAX_ROWS)) &&
              (int'(col) < extent_of(cols_reg, MAX_COLS));
    res = '0;
    case (op)
      OP_WRITE: begin
        if (in_grid) life_grid[row][col] = val;
        return 1'b0;
      end
      OP_STEP: begin
        advance_generation();
        res.done = 1'b1;
        return 1'b1;
      end
      OP_READ: begin
        res.alive = in_grid ? life_grid[row][col] : 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item after a random gap (none when gapless or no_idle is set) and waits for
  // its transfer. Entered and left at a falling edge; valid is left high so that a following item can go straight on.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic val,
                           input bit fixed, input cell_result_t fixed_res,
                           input bit gapless);
    int gap;
    bit has_res;
    cell_result_t res;
    gap = (no_idle || gapless) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.operation  = op;
    in_bus.row        = row;
    in_bus.col        = col;
    in_bus.cell_value = val;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    has_res = predict_cell_op(op, row, col, val, res);
    if (has_res) expected_results.push_back(fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  // Stops offering items and waits until every expected result has been transferred,
  // then lets the block finish any trailing write before anything else happens.
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  // Writes one size register while the block is idle.
  task automatic write_size(input cfg_idx_t idx, input logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_GRID_ROWS) begin
      rows_reg = value;
    end else begin
      cols_reg = value;
    end
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // A random phase at one grid size. Most positions fall inside the grid in use so
  // that writes build up live patterns for the generations to work on; the rest
  // range over every position the fields allow.
  task automatic run_phase(input logic [SIZE_W-1:0] rows_raw,
                           input logic [SIZE_W-1:0] cols_raw,
                           input int n_items, input bit back_to_back);
    int rows;
    int cols;
    int pick;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    logic v;
    write_size(CFG_GRID_ROWS, rows_raw);
    write_size(CFG_GRID_COLS, cols_raw);
    rows = extent_of(rows_raw, MAX_ROWS);
    cols = extent_of(cols_raw, MAX_COLS);
    no_idle = back_to_back;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        op = OP_WRITE;
      end else if (pick < 80) begin
        op = OP_READ;
      end else if (pick < 95) begin
        op = OP_STEP;
      end else begin
        op = OP_UNUSED;
      end
      if ($urandom_range(0, 99) < 85) begin
        r = POS_W'($urandom_range(0, rows - 1));
        c = POS_W'($urandom_range(0, cols - 1));
      end else begin
        r = POS_W'($urandom_range(0, 63));
        c = POS_W'($urandom_range(0, 63));
      end
      v = ($urandom_range(0, 99) < 60);
      send_item(op, r, c, v, 1'b0, '0, 1'b0);
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while reads and generations are
  // offered back to back, so the output register fills and the input stalls.
  // Afterwards the sender pauses until every expected result has come.
  task automatic flood_under_hold();
    logic [OP_W-1:0] op;
    hold_request = 1'b1;
    repeat (12) begin
      op = ($urandom_range(0, 3) == 0) ? OP_STEP : OP_READ;
      send_item(op, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0,
                1'b0, '0, 1'b1);
    end
    wait_drained();
  endtask

  // Receiver: draws a stall before each result, or serves the long hold-off when
  // asked, then takes the next transfer and checks it against the oldest expectation.
  initial begin
    int stall;
    cell_result_t want;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result cell_alive=%0b step_done=%0b",
                 $time, out_bus.cell_alive, out_bus.step_done);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.cell_alive !== want.alive) begin
          $display("%0t: cell_alive mismatch, expected %0b, actual %0b",
                   $time, want.alive, out_bus.cell_alive);
          error_count++;
        end
        if (out_bus.step_done !== want.done) begin
          $display("%0t: step_done mismatch, expected %0b, actual %0b",
                   $time, want.done, out_bus.step_done);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel, or reset, restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("life_generation_engine_unit regression: fail");
    $finish;
  end

  // Main sequence: reset, the directed table, then random phases over several sizes,
  // the extremes and out-of-range register values among them, and a flood under a long hold-off.
  initial begin
    error_count       = 0;
    no_idle           = 1'b0;
    hold_request      = 1'b0;
    rows_reg          = SIZE_W'(MAX_ROWS);
    cols_reg          = SIZE_W'(MAX_COLS);
    life_grid         = '{default: '{default: 1'b0}};
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_WRITE;
    in_bus.row        = '0;
    in_bus.col        = '0;
    in_bus.cell_value = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_GRID_ROWS;
    cfg_bus.data      = '0;
    rst_n             = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_SET_ROWS: write_size(CFG_GRID_ROWS, DIRECTED[i].size);
        ROW_SET_COLS: write_size(CFG_GRID_COLS, DIRECTED[i].size);
        default: send_item(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                           DIRECTED[i].val, DIRECTED[i].fixed,
                           cell_result_t'{DIRECTED[i].alive, DIRECTED[i].done}, 1'b0);
      endcase
    end

    run_phase(7'd6, 7'd6, 20, 1'b0);
    run_phase(7'd0, 7'd0, 8, 1'b1);
    run_phase(7'd127, 7'd127, 15, 1'b0);
    run_phase(7'd1, 7'd64, 15, 1'b1);
    run_phase(7'd65, 7'd1, 15, 1'b0);
    run_phase(7'd5, 7'd9, 15, 1'b0);
    flood_under_hold();
    run_phase(SIZE_W'($urandom_range(1, 12)), SIZE_W'($urandom_range(1, 12)), 15, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("life_generation_engine_unit regression: pass");
    end else begin
      $display("life_generation_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lge_pkg.sv
rtl/lge_in_if.sv
rtl/lge_out_if.sv
rtl/lge_cfg_if.sv
rtl/lge_ctrl.sv
rtl/lge_datapath.sv
rtl/life_generation_engine_unit.sv
sim/tb_life_generation_engine_unit.sv
